// File: rtl/vfp_pkg.sv
// Shared types and constants of the video frame packetizer.
package vfp_pkg;

  localparam int PACKET_BYTES_DEF     = 512;
  localparam int NUM_ALT_SETTINGS_DEF = 2;
  localparam int HEADER_BYTES         = 2;

  localparam logic [15:0] IDLE_INDEX = 16'hffff;

  localparam logic [1:0] MODE_SEL_ALT = 2'd0;
  localparam logic [1:0] MODE_SOF     = 2'd1;
  localparam logic [1:0] MODE_EP_RDY  = 2'd2;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_FULL  = 3'd1;
  localparam logic [2:0] ACT_LAST  = 3'd2;
  localparam logic [2:0] ACT_HDR   = 3'd3;
  localparam logic [2:0] ACT_STALL = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  alt_setting;
    logic        frame_ready;
    logic [15:0] frame_size;
  } vfp_in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  packet_length;
    logic [19:0] payload_offset;
    logic        frame_id;
    logic        take_frame;
    logic        flush_endpoint;
    logic [3:0]  current_alt;
  } vfp_out_t;

  typedef struct packed {
    vfp_in_t     item;
    logic [15:0] count;
    logic [9:0]  final_len;
  } vfp_div_t;

endpackage

// File: rtl/video_frame_packetizer.sv
// Video frame packetizer top level: event decode, stream state and result register.
//
// Takes one event per cycle at full rate (alternate-setting select, start of
// frame, endpoint ready) while no held result stalls it, and returns exactly
// one result per event, in order. Each event passes through the frame-size
// divider stages (reciprocal multiply, then remainder) and then the stream state
// update that writes the result register. A held result stalls the pipeline
// only once all three stages are full.
module video_frame_packetizer
  import vfp_pkg::*;
#(
  parameter int PACKET_BYTES     = PACKET_BYTES_DEF,
  parameter int NUM_ALT_SETTINGS = NUM_ALT_SETTINGS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  vfp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output vfp_out_t out_data
);

  localparam int PAYLOAD = PACKET_BYTES - HEADER_BYTES;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ARMED  = 2'd1,
    PH_STREAM = 2'd2
  } phase_t;

  logic     dv_valid;
  logic     dv_ready;
  vfp_div_t dv_data;
  logic     fire;

  logic [3:0]  alt_now_r,   alt_now_nxt;
  phase_t      phase_r,     phase_nxt;
  logic        sending_r,   sending_nxt;
  logic [15:0] pkt_idx_r,   pkt_idx_nxt;
  logic        fid_r,       fid_nxt;
  logic [19:0] rd_off_r,    rd_off_nxt;
  logic [15:0] ppf_r,       ppf_nxt;
  logic [9:0]  final_len_r, final_len_nxt;
  logic        out_valid_r;
  vfp_out_t    out_data_r,  out_data_nxt;

  logic [19:0] start;

  vfp_size_div #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(dv_valid),
    .out_ready(dv_ready),
    .out_data (dv_data)
  );

  assign dv_ready = !out_valid_r || out_ready;
  assign fire     = dv_valid && dv_ready;

  always_comb begin
    alt_now_nxt   = alt_now_r;
    phase_nxt     = phase_r;
    sending_nxt   = sending_r;
    pkt_idx_nxt   = pkt_idx_r;
    fid_nxt       = fid_r;
    rd_off_nxt    = rd_off_r;
    ppf_nxt       = ppf_r;
    final_len_nxt = final_len_r;
    start         = rd_off_r;
    out_data_nxt  = '0;

    case (dv_data.item.mode)
      MODE_SEL_ALT: begin
        if (16'(dv_data.item.alt_setting) < 16'(NUM_ALT_SETTINGS)) begin
          alt_now_nxt = dv_data.item.alt_setting[3:0];
          if (dv_data.item.alt_setting[3:0] == 4'd1) begin
            phase_nxt = PH_ARMED;
          end else begin
            phase_nxt                   = PH_IDLE;
            out_data_nxt.flush_endpoint = 1'b1;
          end
        end else begin
          out_data_nxt.action = ACT_STALL;
        end
      end
      MODE_SOF: begin
        if (phase_r == PH_ARMED) begin
          out_data_nxt.action        = ACT_HDR;
          out_data_nxt.packet_length = 10'(HEADER_BYTES);
          phase_nxt                  = PH_STREAM;
        end
      end
      MODE_EP_RDY: begin
        if (sending_r) begin
          pkt_idx_nxt = pkt_idx_r + 16'd1;
        end
        if (!sending_r && dv_data.item.frame_ready) begin
          sending_nxt             = 1'b1;
          out_data_nxt.take_frame = 1'b1;
          pkt_idx_nxt             = 16'd0;
          fid_nxt                 = !fid_r;
          ppf_nxt                 = dv_data.count;
          final_len_nxt           = dv_data.final_len;
          start                   = '0;
        end
        rd_off_nxt = start + 20'(PAYLOAD);
        if (phase_r == PH_STREAM) begin
          if (pkt_idx_nxt < ppf_nxt - 16'd1) begin
            out_data_nxt.action         = ACT_FULL;
            out_data_nxt.packet_length  = 10'(PACKET_BYTES);
            out_data_nxt.payload_offset = start;
          end else if (sending_nxt) begin
            out_data_nxt.action         = ACT_LAST;
            out_data_nxt.packet_length  = final_len_nxt;
            out_data_nxt.payload_offset = start;
            sending_nxt                 = 1'b0;
            rd_off_nxt                  = '0;
          end else begin
            out_data_nxt.action        = ACT_HDR;
            out_data_nxt.packet_length = 10'(HEADER_BYTES);
            rd_off_nxt                 = '0;
          end
        end else begin
          pkt_idx_nxt = IDLE_INDEX;
        end
      end
      default: begin
      end
    endcase

    out_data_nxt.frame_id    = fid_nxt;
    out_data_nxt.current_alt = alt_now_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_now_r   <= '0;
      phase_r     <= PH_IDLE;
      sending_r   <= 1'b0;
      pkt_idx_r   <= IDLE_INDEX;
      fid_r       <= 1'b0;
      rd_off_r    <= '0;
      ppf_r       <= 16'd1;
      final_len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        alt_now_r   <= alt_now_nxt;
        phase_r     <= phase_nxt;
        sending_r   <= sending_nxt;
        pkt_idx_r   <= pkt_idx_nxt;
        fid_r       <= fid_nxt;
        rd_off_r    <= rd_off_nxt;
        ppf_r       <= ppf_nxt;
        final_len_r <= final_len_nxt;
        out_data_r  <= out_data_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_take_flush_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.take_frame && out_data_r.flush_endpoint))
    else $error("take_frame and flush_endpoint in one transaction");

  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.action == ACT_NONE || out_data_r.action == ACT_STALL)
      |-> out_data_r.packet_length == 10'd0)
    else $error("nonzero length with no packet sent");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    fire && out_data_nxt.action == ACT_LAST |=> !sending_r && rd_off_r == 20'd0)
    else $error("frame still in flight after last packet");

  a_take_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    fire && out_data_nxt.take_frame && out_data_nxt.action != ACT_LAST
      |=> sending_r && fid_r != $past(fid_r))
    else $error("buffer swap without a new frame");

endmodule

// File: rtl/vfp_size_div.sv
// Two-stage frame-size divider: packet count and last packet length per event.
module vfp_size_div
  import vfp_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  vfp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output vfp_div_t out_data
);

  localparam int PAYLOAD   = PACKET_BYTES - HEADER_BYTES;
  localparam int DIV_SHIFT = 16 + $clog2(PAYLOAD);
  localparam logic [16:0] RECIP =
    17'(((64'd1 << DIV_SHIFT) + 64'(PAYLOAD) - 64'd1) / 64'(PAYLOAD));

  logic        s1_valid_r;
  vfp_in_t     s1_item_r;
  logic [15:0] s1_q_r;
  logic        s2_valid_r;
  vfp_div_t    s2_data_r;

  logic        s2_free;
  logic        s1_free;
  logic [32:0] prod;
  logic [15:0] q_nxt;
  logic [15:0] qd;
  logic [9:0]  rem;
  logic        sat;
  logic [15:0] count_nxt;
  logic [9:0]  final_nxt;

  assign s2_free  = !s2_valid_r || out_ready;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;

  assign prod  = 33'(in_data.frame_size) * 33'(RECIP);
  assign q_nxt = 16'(prod >> DIV_SHIFT);

  assign qd        = s1_q_r * 16'(PAYLOAD);
  assign rem       = 10'(s1_item_r.frame_size - qd);
  assign sat       = (s1_q_r == IDLE_INDEX);
  assign count_nxt = sat ? IDLE_INDEX : s1_q_r + 16'd1;
  assign final_nxt = 10'({1'b0, rem} + (sat ? 11'(PAYLOAD) : 11'd0) + 11'(HEADER_BYTES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_valid;
        s1_item_r  <= in_data;
        s1_q_r     <= q_nxt;
      end
      if (s2_free) begin
        s2_valid_r          <= s1_valid_r;
        s2_data_r.item      <= s1_item_r;
        s2_data_r.count     <= count_nxt;
        s2_data_r.final_len <= final_nxt;
      end
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

endmodule

// File: test/tb_video_frame_packetizer.sv
// Self-checking testbench of the packetizer: directed and random event streams checked against a predictor.
`timescale 1ns / 1ps

module tb_video_frame_packetizer;
  import vfp_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PAYLOAD_BYTES = PACKET_BYTES_DEF - HEADER_BYTES;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_LEN = 300;
  localparam int PHASE_EVENTS = 465;

  typedef enum logic [1:0] {PH_IDLE, PH_ARMED, PH_STREAM} stream_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  vfp_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vfp_out_t out_data;

  vfp_in_t pending_events[$];
  vfp_out_t expected_packets[$];
  vfp_out_t want_pkt;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int events_queued = 0;
  int errors = 0;
  int stall_cycles = 0;
  int send_idle_tbl[4] = '{0, 49, 0, 24};
  int recv_stall_tbl[4] = '{0, 0, 49, 24};

  logic [3:0] alt_sel;
  stream_phase_t stream_phase;
  logic frame_active;
  logic [15:0] pkt_idx;
  logic fid;
  logic [19:0] rd_offset;
  logic [15:0] pkts_in_frame;
  logic [9:0] last_len;

  video_frame_packetizer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic vfp_out_t packetize_event(vfp_in_t ev);
    vfp_out_t r;
    int count;
    logic [19:0] start;
    r = '0;
    case (ev.mode)
      MODE_SEL_ALT: begin
        if (int'(ev.alt_setting) < NUM_ALT_SETTINGS_DEF) begin
          alt_sel = ev.alt_setting[3:0];
          if (alt_sel == 4'd1) begin
            stream_phase = PH_ARMED;
          end else begin
            stream_phase = PH_IDLE;
            r.flush_endpoint = 1'b1;
          end
        end else begin
          r.action = ACT_STALL;
        end
      end
      MODE_SOF: begin
        if (stream_phase == PH_ARMED) begin
          r.action = ACT_HDR;
          r.packet_length = 10'(HEADER_BYTES);
          stream_phase = PH_STREAM;
        end
      end
      MODE_EP_RDY: begin
        if (frame_active) pkt_idx = pkt_idx + 16'd1;
        if (!frame_active && ev.frame_ready) begin
          count = int'(ev.frame_size) / PAYLOAD_BYTES + 1;
          if (count > 65535) count = 65535;
          frame_active = 1'b1;
          r.take_frame = 1'b1;
          pkt_idx = '0;
          fid = ~fid;
          rd_offset = '0;
          pkts_in_frame = 16'(count);
          last_len = 10'(int'(ev.frame_size) - (count - 1) * PAYLOAD_BYTES + HEADER_BYTES);
        end
        start = rd_offset;
        rd_offset = rd_offset + 20'(PAYLOAD_BYTES);
        if (stream_phase == PH_STREAM) begin
          if (int'(pkt_idx) < int'(pkts_in_frame) - 1) begin
            r.action = ACT_FULL;
            r.packet_length = 10'(PACKET_BYTES_DEF);
            r.payload_offset = start;
          end else if (frame_active) begin
            r.action = ACT_LAST;
            r.packet_length = last_len;
            r.payload_offset = start;
            frame_active = 1'b0;
            rd_offset = '0;
          end else begin
            r.action = ACT_HDR;
            r.packet_length = 10'(HEADER_BYTES);
            rd_offset = '0;
          end
        end else begin
          pkt_idx = IDLE_INDEX;
        end
      end
      default: ;
    endcase
    r.frame_id = fid;
    r.current_alt = alt_sel;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= 50) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_events.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      alt_sel <= '0;
      stream_phase <= PH_IDLE;
      frame_active <= 1'b0;
      pkt_idx <= IDLE_INDEX;
      fid <= 1'b0;
      rd_offset <= '0;
      pkts_in_frame <= 16'd1;
      last_len <= '0;
    end else begin
      if (in_valid && in_ready) expected_packets.push_back(packetize_event(in_data));
      if (out_valid && out_ready) begin
        if (expected_packets.size() == 0) begin
          errors++;
          if (errors <= 50) $error("result transaction with no expectation pending");
        end else begin
          want_pkt = expected_packets.pop_front();
          check_field("action", want_pkt.action, out_data.action);
          check_field("packet_length", want_pkt.packet_length, out_data.packet_length);
          check_field("payload_offset", want_pkt.payload_offset, out_data.payload_offset);
          check_field("frame_id", want_pkt.frame_id, out_data.frame_id);
          check_field("take_frame", want_pkt.take_frame, out_data.take_frame);
          check_field("flush_endpoint", want_pkt.flush_endpoint, out_data.flush_endpoint);
          check_field("current_alt", want_pkt.current_alt, out_data.current_alt);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic push_event(logic [1:0] mode, int alt, int ready, int size);
    vfp_in_t ev;
    ev.mode = mode;
    ev.alt_setting = 8'(alt);
    ev.frame_ready = 1'(ready);
    ev.frame_size = 16'(size);
    pending_events.push_back(ev);
    events_queued++;
  endtask

  function automatic int rand_frame_size();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom_range(0, 2600);
    if (pick < 8) return $urandom_range(1, 128) * PAYLOAD_BYTES + $urandom_range(0, 2) - 1;
    return $urandom_range(0, 65535);
  endfunction

  function automatic int rand_alt();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 3);
    return $urandom_range(0, 255);
  endfunction

  task automatic push_ready_burst(int n);
    repeat (n) push_event(MODE_EP_RDY, $urandom_range(0, 255), ($urandom_range(0, 9) < 6),
                          rand_frame_size());
  endtask

  task automatic gen_sequence();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      if ($urandom_range(0, 3) != 0)
        push_event(MODE_SEL_ALT, 1, $urandom_range(0, 1), rand_frame_size());
      if ($urandom_range(0, 3) != 0)
        push_event(MODE_SOF, $urandom_range(0, 255), $urandom_range(0, 1), rand_frame_size());
      push_ready_burst($urandom_range(1, 12));
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 4))
        push_event(2'($urandom_range(0, 3)), rand_alt(), $urandom_range(0, 1),
                   $urandom_range(0, 65535));
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          push_event(MODE_SEL_ALT, 0, $urandom_range(0, 1), rand_frame_size());
          push_ready_burst($urandom_range(1, 4));
        end
        1: begin
          push_event(MODE_SEL_ALT, 1, $urandom_range(0, 1), rand_frame_size());
          push_ready_burst($urandom_range(1, 4));
        end
        default: begin
          push_event(MODE_SOF, rand_alt(), $urandom_range(0, 1), rand_frame_size());
          push_event(MODE_SOF, rand_alt(), $urandom_range(0, 1), rand_frame_size());
          push_event(MODE_SEL_ALT, $urandom_range(2, 255), $urandom_range(0, 1),
                     rand_frame_size());
        end
      endcase
    end
  endtask

  task automatic drain_all();
    while (pending_events.size() != 0 || in_valid || expected_packets.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_event(MODE_SEL_ALT, 0, 0, 0);
    push_event(MODE_SEL_ALT, 255, 1, 65535);
    push_event(MODE_SEL_ALT, 2, 0, 0);
    push_event(MODE_SOF, 255, 1, 65535);
    push_event(MODE_EP_RDY, 0, 0, 65535);
    push_event(MODE_UNUSED, 255, 1, 65535);
    push_event(MODE_SEL_ALT, 1, 0, 0);
    push_event(MODE_EP_RDY, 0, 1, 0);
    push_event(MODE_SOF, 0, 0, 0);
    push_event(MODE_EP_RDY, 0, 0, 0);
    push_event(MODE_EP_RDY, 0, 0, 0);
    push_event(MODE_SOF, 0, 0, 0);
    push_event(MODE_EP_RDY, 0, 1, 509);
    push_event(MODE_EP_RDY, 0, 1, 510);
    push_event(MODE_EP_RDY, 0, 1, 1);
    push_event(MODE_EP_RDY, 255, 1, 65535);
    push_event(MODE_EP_RDY, 0, 0, 0);
    push_event(MODE_EP_RDY, 0, 0, 0);
    push_event(MODE_EP_RDY, 0, 0, 0);
    push_event(MODE_SEL_ALT, 0, 1, 65535);
    push_event(MODE_EP_RDY, 0, 0, 0);
    push_event(MODE_SEL_ALT, 1, 0, 0);
    push_event(MODE_SOF, 0, 0, 0);
    push_event(MODE_EP_RDY, 0, 1, 1021);
    push_event(MODE_SEL_ALT, 15, 0, 0);
    drain_all();

    // hold the result side while the sender keeps offering
    hold_off_cycles = HOLD_OFF_LEN;
    repeat (8) gen_sequence();
    while (hold_off_cycles != 0) @(negedge clk);
    drain_all();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_idle_tbl[p];
      recv_stall_pct = recv_stall_tbl[p];
      for (int target = events_queued + PHASE_EVENTS; events_queued < target; )
        gen_sequence();
      while (pending_events.size() != 0) @(negedge clk);
    end
    drain_all();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/vfp_pkg.sv
rtl/vfp_size_div.sv
rtl/video_frame_packetizer.sv
test/tb_video_frame_packetizer.sv
